// ===== hdl/hps_pkg.sv =====
package hps_pkg;

    // table geometry
    localparam int MAX_PARTITIONS = 256;
    localparam int TBL_DEPTH      = MAX_PARTITIONS + 1;
    localparam int TBL_W          = 21;
    localparam int ADDR_W         = 9;
    localparam int BUCKET_W       = 8;
    localparam int POS_W          = 20;
    localparam int KEY_W          = 32;
    localparam int IDX_W          = 20;
    localparam int OPC_W          = 3;
    localparam int CNT_W          = 9;

    // element count clamp
    localparam logic [TBL_W-1:0] MAX_ELEMENTS = 21'd1048576;

    // stream payload widths
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 104;

    // opcodes
    localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OPC_W-1:0] OP_COUNT  = 3'd1;
    localparam logic [OPC_W-1:0] OP_PREFIX = 3'd2;
    localparam logic [OPC_W-1:0] OP_PLACE  = 3'd3;
    localparam logic [OPC_W-1:0] OP_READ   = 3'd4;

    // register indexes
    localparam logic [1:0] REG_NUM_PARTS = 2'd0;
    localparam logic [1:0] REG_MODE      = 2'd1;
    localparam logic [1:0] REG_NUM_ELEMS = 2'd2;
    localparam logic [1:0] REG_ROT_BKT   = 2'd3;

    // sequencer step counts
    localparam logic [CNT_W-1:0] HASH_LAST = 9'd5;
    localparam logic [CNT_W-1:0] DIV_LAST  = 9'd31;
    localparam logic [CNT_W-1:0] TBL_LAST  = 9'(TBL_DEPTH - 1);

    // one step of the integer mix, selected by step number
    function automatic logic [KEY_W-1:0] mix_step(input logic [KEY_W-1:0] v,
                                                  input logic [2:0] step);
        logic [KEY_W-1:0] r;
        begin
            case (step)
                3'd0:    r = v + ~(v << 15);
                3'd1:    r = v ^ (v >> 10);
                3'd2:    r = v + (v << 3);
                3'd3:    r = v ^ (v >> 6);
                3'd4:    r = v + ~(v << 11);
                3'd5:    r = v ^ (v >> 16);
                default: r = v;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== hdl/hash_partition_scatter_top.sv =====
// Hash partitioner with a bucket table of 257 entries.
// Input items arrive on the s-side stream: tuser carries the opcode (clear,
// count, prefix, place, read), tdata the key, index and bucket select.
// Every accepted item gives exactly one result item on the m-side stream.
// Configuration registers are written through i_cfg_we / i_cfg_index /
// i_cfg_data and are taken at any time; change them only while idle.
// Steps per item, from accept to result valid; each ends in the output step:
//   count, place: 6 mix steps, then 32 divide steps (modulo mode, one
//   remainder bit a cycle) or none (radix mode), then table read and
//   entry update.
//   prefix: read, then write, each table entry from 0 up to the partition count.
//   clear: one table entry a cycle over all 257 entries.
//   read: table read, or none when rejected; unknown opcode: none.
// One item is in work at a time; tready is high only while idle.
// After reset all 257 table entries are cleared before the first item
// is taken. A result waits in the output register while the receiver
// stalls; the next item may be accepted meanwhile, and its result holds
// in the sequencer until the output register is free.
module hash_partition_scatter_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [20:0]                  i_cfg_data,
    // input stream
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [hps_pkg::S_DATA_W-1:0] i_s_tdata,  // key, item_index, bucket_select
    input  logic [hps_pkg::OPC_W-1:0]    i_s_tuser,  // opcode
    // result stream
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [hps_pkg::M_DATA_W-1:0] o_m_tdata,  // bucket, position, key_out,
                                                     // index_out, boundary
    output logic [0:0]                   o_m_tuser   // status
);

    // sequencer states
    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_HASH   = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_RD     = 4'd4;
    localparam logic [3:0] S_UPD    = 4'd5;
    localparam logic [3:0] S_PFX_RD = 4'd6;
    localparam logic [3:0] S_PFX_WR = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    // configuration registers
    logic [8:0]                     r_num_parts;
    logic                           r_mode;
    logic [hps_pkg::TBL_W-1:0]      r_num_elems;
    logic [8:0]                     r_rot_bkt;

    // sequencer state
    logic [3:0]                     r_state;
    logic [hps_pkg::CNT_W-1:0]      r_cnt;
    logic                           r_clr_out;
    logic [hps_pkg::OPC_W-1:0]      r_op;
    logic [hps_pkg::KEY_W-1:0]      r_key;
    logic [hps_pkg::IDX_W-1:0]      r_idx;
    logic [hps_pkg::KEY_W-1:0]      r_hash;
    logic [7:0]                     r_rem;
    logic [hps_pkg::BUCKET_W-1:0]   r_bucket;
    logic [hps_pkg::ADDR_W-1:0]     r_addr;
    logic [hps_pkg::TBL_W-1:0]      r_acc;
    logic [hps_pkg::TBL_W-1:0]      r_base;

    // pending result fields
    logic [hps_pkg::POS_W-1:0]      r_res_pos;
    logic [hps_pkg::TBL_W-1:0]      r_res_bnd;
    logic                           r_res_sts;
    logic                           r_res_echo;

    // output register
    logic                           r_out_valid;
    logic [hps_pkg::M_DATA_W-1:0]   r_out_data;
    logic                           r_out_sts;

    // bucket table
    logic [hps_pkg::TBL_W-1:0]      r_mem [0:hps_pkg::TBL_DEPTH-1];
    logic [hps_pkg::TBL_W-1:0]      r_rdata;
    logic                           mem_we;
    logic [hps_pkg::ADDR_W-1:0]     mem_waddr;
    logic [hps_pkg::TBL_W-1:0]      mem_wdata;
    logic [hps_pkg::ADDR_W-1:0]     rd_addr;

    // derived values
    logic [8:0]                     eff_p;
    logic [8:0]                     rot_sel;
    logic [3:0]                     lz9;
    logic [5:0]                     radix_sh;
    logic [hps_pkg::BUCKET_W-1:0]   radix_bkt;
    logic [8:0]                     rem_sh;
    logic [8:0]                     rem_nx;
    logic [hps_pkg::TBL_W-1:0]      pfx_sum;
    logic [hps_pkg::TBL_W-1:0]      ne_eff;
    logic [hps_pkg::TBL_W-1:0]      pos_full;
    logic                           s_acc;
    logic                           out_free;
    logic [hps_pkg::KEY_W-1:0]      in_key;
    logic [hps_pkg::IDX_W-1:0]      in_idx;
    logic [8:0]                     in_sel;

    assign in_key = i_s_tdata[31:0];
    assign in_idx = i_s_tdata[51:32];
    assign in_sel = i_s_tdata[60:52];

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_sts;

    // effective partition count and rotation entry
    always_comb begin
        if (r_num_parts == 9'd0) begin
            eff_p = 9'd1;
        end else if (r_num_parts > 9'(hps_pkg::MAX_PARTITIONS)) begin
            eff_p = 9'(hps_pkg::MAX_PARTITIONS);
        end else begin
            eff_p = r_num_parts;
        end
        rot_sel = (r_rot_bkt > eff_p) ? eff_p : r_rot_bkt;
    end

    // radix bucket: shift by 24 plus leading zeros of the 9-bit count
    always_comb begin
        lz9 = 4'd9;
        for (int k = 0; k < 9; k++) begin
            if (eff_p[k]) begin
                lz9 = 4'(8 - k);
            end
        end
        radix_sh = 6'd24 + {2'b00, lz9};
        if (radix_sh >= 6'd32) begin
            radix_bkt = '0;
        end else begin
            radix_bkt = 8'(r_hash >> radix_sh);
        end
    end

    // one restoring divide step
    always_comb begin
        rem_sh = {r_rem, r_hash[31]};
        rem_nx = (rem_sh >= eff_p) ? (rem_sh - eff_p) : rem_sh;
    end

    // place position and prefix sum
    always_comb begin
        pfx_sum  = r_acc + r_rdata;
        ne_eff   = (r_num_elems > hps_pkg::MAX_ELEMENTS) ? hps_pkg::MAX_ELEMENTS
                                                         : r_num_elems;
        pos_full = (r_rdata < r_base) ? (r_rdata - r_base + ne_eff)
                                      : (r_rdata - r_base);
    end

    // table port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_rdata + 21'd1;
        rd_addr   = r_addr;
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = '0;
            end
            S_UPD: begin
                mem_we = (r_op == hps_pkg::OP_COUNT) || (r_op == hps_pkg::OP_PLACE);
            end
            S_PFX_RD: begin
                rd_addr = r_cnt;
            end
            S_PFX_WR: begin
                mem_we    = (r_cnt != '0);
                mem_waddr = r_cnt;
                mem_wdata = pfx_sum;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // bucket table memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_parts <= 9'd1;
            r_mode      <= 1'b0;
            r_num_elems <= 21'd1;
            r_rot_bkt   <= 9'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hps_pkg::REG_NUM_PARTS: r_num_parts <= i_cfg_data[8:0];
                hps_pkg::REG_MODE:      r_mode      <= i_cfg_data[0];
                hps_pkg::REG_NUM_ELEMS: r_num_elems <= i_cfg_data;
                hps_pkg::REG_ROT_BKT:   r_rot_bkt   <= i_cfg_data[8:0];
                default:                r_mode      <= r_mode;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_cnt       <= '0;
            r_clr_out   <= 1'b0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register empties when taken, unless reloaded below
            if (r_out_valid && i_m_tready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                // table sweep, after reset or on clear
                S_CLR: begin
                    if (r_cnt == hps_pkg::TBL_LAST) begin
                        r_cnt   <= '0;
                        r_state <= r_clr_out ? S_OUT : S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 9'd1;
                    end
                end
                // take an item and dispatch on opcode
                S_IDLE: begin
                    if (s_acc) begin
                        r_op       <= i_s_tuser;
                        r_key      <= in_key;
                        r_idx      <= in_idx;
                        r_hash     <= in_key;
                        r_bucket   <= '0;
                        r_res_pos  <= '0;
                        r_res_bnd  <= '0;
                        r_res_sts  <= (i_s_tuser == hps_pkg::OP_READ) && (in_sel > eff_p);
                        r_res_echo <= 1'b0;
                        r_cnt      <= '0;
                        case (i_s_tuser)
                            hps_pkg::OP_CLEAR: begin
                                r_clr_out <= 1'b1;
                                r_state   <= S_CLR;
                            end
                            hps_pkg::OP_COUNT,
                            hps_pkg::OP_PLACE: begin
                                r_state <= S_HASH;
                            end
                            hps_pkg::OP_PREFIX: begin
                                r_state <= S_PFX_RD;
                            end
                            hps_pkg::OP_READ: begin
                                if (in_sel > eff_p) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_addr  <= in_sel;
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                // integer mix, one step a cycle
                S_HASH: begin
                    r_hash <= hps_pkg::mix_step(r_hash, r_cnt[2:0]);
                    if (r_cnt == hps_pkg::HASH_LAST) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_state <= r_mode ? S_RD : S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 9'd1;
                    end
                end
                // modulo by partition count, one quotient bit a cycle
                S_DIV: begin
                    r_rem  <= rem_nx[7:0];
                    r_hash <= {r_hash[30:0], 1'b0};
                    if (r_cnt == hps_pkg::DIV_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_cnt <= r_cnt + 9'd1;
                    end
                end
                // table read issue; bucket settles here for count and place
                S_RD: begin
                    if (r_op != hps_pkg::OP_READ) begin
                        if (r_mode) begin
                            r_bucket <= radix_bkt;
                            r_addr   <= {1'b0, radix_bkt} +
                                        ((r_op == hps_pkg::OP_COUNT) ? 9'd1 : 9'd0);
                        end else begin
                            r_bucket <= r_rem;
                            r_addr   <= {1'b0, r_rem} +
                                        ((r_op == hps_pkg::OP_COUNT) ? 9'd1 : 9'd0);
                        end
                        // read address must settle first, so the state repeats before the update
                        r_cnt   <= r_cnt + 9'd1;
                        r_state <= (r_cnt != '0) ? S_UPD : S_RD;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                // read data back: update entry for count and place, form result
                S_UPD: begin
                    if (r_op == hps_pkg::OP_PLACE) begin
                        r_res_pos  <= pos_full[hps_pkg::POS_W-1:0];
                        r_res_echo <= 1'b1;
                    end else if (r_op == hps_pkg::OP_READ) begin
                        r_res_bnd <= r_rdata;
                    end
                    r_state <= S_OUT;
                end
                // prefix walk: read entry
                S_PFX_RD: begin
                    r_state <= S_PFX_WR;
                end
                // prefix walk: accumulate and write back
                S_PFX_WR: begin
                    if (r_cnt == '0) begin
                        r_acc <= r_rdata;
                    end else begin
                        r_acc <= pfx_sum;
                    end
                    if (r_cnt == rot_sel) begin
                        r_base <= (r_cnt == '0) ? r_rdata : pfx_sum;
                    end
                    if (r_cnt == eff_p) begin
                        r_state <= S_OUT;
                    end else begin
                        r_cnt   <= r_cnt + 9'd1;
                        r_state <= S_PFX_RD;
                    end
                end
                // hand the result to the output register
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_sts   <= r_res_sts;
                        r_out_data  <= {3'b000,
                                        r_res_bnd,
                                        r_res_echo ? r_idx : 20'd0,
                                        r_res_echo ? r_key : 32'd0,
                                        r_res_pos,
                                        r_bucket};
                        r_clr_out   <= 1'b0;
                        r_cnt       <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
